### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned KindW = 2;
  localparam int unsigned RawW = 32;
  localparam int unsigned HeadW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW = 7;

  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_PULL = 2'd1;
  localparam logic [KindW-1:0] KIND_PEEK = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_PULL,
    OP_PEEK,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [RawW-1:0] raw;
  } req_t;

  typedef struct packed {
    logic [HeadW-1:0]   head;
    logic [StatusW-1:0] status;
    logic [OccW-1:0]    occupancy;
  } res_t;

endpackage

### hw/rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded max-priority queue kept as a sorted row of cells.
// ----------------------------------------------------------------------------
// Requests enter through push/full with kind_i (insert, pull, peek) and
// item_value_i; a request is taken when push is high and full is low.
// Results leave through empty/pop; head_value_o, status_o and
// occupancy_o show the oldest result while empty is low, taken when pop
// is high.
// A taken request is written into the request queue, and its result into
// the result register when the cell row takes it from there.
// Throughput: one request per cycle while results are taken; every cell
// compares against the new value in the same cycle, so insert, pull and
// peek are all decided at once across the cell row.
// Equal values leave in arrival order. Insert into a full queue is dropped
// with status full; pull or peek on an empty queue gives status empty.
// Reset empties the queue and drops any pending request and result.
// If pop stays low the result is held, the two-entry request queue fills
// and full rises until results are taken again.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [spq_pkg::KindW-1:0]    kind_i,
  input  logic [spq_pkg::RawW-1:0]     item_value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [spq_pkg::HeadW-1:0]    head_value_o,
  output logic [spq_pkg::StatusW-1:0]  status_o,
  output logic [spq_pkg::OccW-1:0]     occupancy_o
);

  spq_pkg::req_t front_req, back_req;
  spq_pkg::res_t res;
  logic          back_valid, back_pop;

  spq_front u_front (
    .kind_i       (kind_i),
    .item_value_i (item_value_i),
    .req_o        (front_req)
  );

  spq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .full_o  (full),
    .valid_o (back_valid),
    .req_o   (back_req),
    .pop_i   (back_pop)
  );

  spq_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (back_valid),
    .req_i       (back_req),
    .req_pop_o   (back_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign head_value_o = res.head;
  assign status_o = res.status;
  assign occupancy_o = res.occupancy;

endmodule

### hw/rtl/spq_front.sv
// ----------------------------------------------------------------------------
// spq_front
// Decodes an incoming request into an internal operation.
// ----------------------------------------------------------------------------
module spq_front (
  input  logic [spq_pkg::KindW-1:0] kind_i,
  input  logic [spq_pkg::RawW-1:0]  item_value_i,
  output spq_pkg::req_t             req_o
);

  spq_pkg::op_e op;

  always_comb begin
    unique case (kind_i)
      spq_pkg::KIND_INSERT: op = spq_pkg::OP_INSERT;
      spq_pkg::KIND_PULL:   op = spq_pkg::OP_PULL;
      spq_pkg::KIND_PEEK:   op = spq_pkg::OP_PEEK;
      default:              op = spq_pkg::OP_NONE;
    endcase
  end

  assign req_o.op = op;
  assign req_o.raw = item_value_i;

endmodule

### hw/rtl/spq_queue.sv
// ----------------------------------------------------------------------------
// spq_queue
// Two-entry request queue between the decode front and the cell row.
// ----------------------------------------------------------------------------
module spq_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spq_pkg::req_t req_i,
  output logic          full_o,
  output logic          valid_o,
  output spq_pkg::req_t req_o,
  input  logic          pop_i
);

  spq_pkg::req_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign req_o = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("request queue count overflow");
`endif

endmodule

### hw/rtl/spq_back.sv
// ----------------------------------------------------------------------------
// spq_back
// Sorted cell row: every cell compares with the new value in parallel and
// shifts right on insert or left on pull. Holds the result register.
// ----------------------------------------------------------------------------
module spq_back #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  spq_pkg::req_t req_i,
  output logic          req_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output spq_pkg::res_t res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] val_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] below [CAPACITY];
  logic [VALUE_WIDTH-1:0] above [CAPACITY];
  logic [CAPACITY-1:0]    ge;
  logic [CAPACITY-1:0]    prev_ge;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   res_valid_q;
  spq_pkg::res_t          res_q, res_d;
  logic                   take, do_ins, do_pull;
  logic [63:0]            raw_wide, head_wide, cnt_wide;
  logic [VALUE_WIDTH-1:0] ins_v;

  assign take = req_valid_i && (!res_valid_q || pop_i);
  assign req_pop_o = take;
  assign empty_o = !res_valid_q;
  assign res_o = res_q;

  assign raw_wide = 64'(req_i.raw);
  assign ins_v = raw_wide[VALUE_WIDTH-1:0];
  assign head_wide = 64'($signed(val_q[0]));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ge[i] = (CntW'(i) < cnt_q) && ($signed(val_q[i]) >= $signed(ins_v));
    if (i == 0) begin : g_first
      assign prev_ge[i] = 1'b1;
      assign below[i] = ins_v;
    end else begin : g_rest
      assign prev_ge[i] = ge[i-1];
      assign below[i] = val_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above[i] = val_q[i];
    end else begin : g_inner
      assign above[i] = val_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (do_ins && !ge[i]) begin
        val_q[i] <= prev_ge[i] ? ins_v : below[i];
      end else if (do_pull) begin
        val_q[i] <= above[i];
      end
    end
  end

  always_comb begin
    res_d = '0;
    cnt_d = cnt_q;
    do_ins = 1'b0;
    do_pull = 1'b0;
    unique case (req_i.op) inside
      spq_pkg::OP_INSERT: begin
        if (cnt_q == CntW'(CAPACITY)) begin
          res_d.status = spq_pkg::STATUS_FULL;
        end else begin
          do_ins = take;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      spq_pkg::OP_PULL, spq_pkg::OP_PEEK: begin
        if (cnt_q == '0) begin
          res_d.status = spq_pkg::STATUS_EMPTY;
        end else begin
          res_d.head = head_wide[spq_pkg::HeadW-1:0];
          if (req_i.op == spq_pkg::OP_PULL) begin
            do_pull = take;
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      default: ;
    endcase
    cnt_wide = 64'(cnt_d);
    res_d.occupancy = cnt_wide[spq_pkg::OccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_q <= cnt_d;
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_pull_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_i.op == spq_pkg::OP_PULL && cnt_q != '0
    |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("pull did not remove one entry");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status == spq_pkg::STATUS_FULL |-> cnt_q == CntW'(CAPACITY))
    else $error("full status while queue not full");
`endif

endmodule

### tb/sv/sorted_priority_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_tb
// Self-checking bench for the sorted max-priority queue.
// ----------------------------------------------------------------------------
// Requests go in through push/full and results come back through empty/pop.
// A behavioral sorted list tracks the queue contents and predicts every
// result; each popped result is checked field by field against the oldest
// prediction. A short directed table covers the empty, extreme and unused-kind
// cases; random fill/drain sweeps then push the queue to full and back to
// empty many times under varying sender and receiver idle rates.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb;

  localparam int Capacity = 64;
  localparam int RxHoldCycles = 100;
  localparam int DrainGuard = 50000;

  typedef struct {
    spq_pkg::op_e  op;
    logic [31:0]   val;
    bit            typed;
    spq_pkg::res_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [spq_pkg::KindW-1:0] kind_i = spq_pkg::KIND_INSERT;
  logic [spq_pkg::RawW-1:0] item_value_i = '0;
  logic full;
  logic empty;
  logic [spq_pkg::HeadW-1:0] head_value_o;
  logic [spq_pkg::StatusW-1:0] status_o;
  logic [spq_pkg::OccW-1:0] occupancy_o;

  bit req_typed = 1'b0;
  spq_pkg::res_t req_want = '0;

  logic signed [31:0] held_vals[Capacity];
  int held_count = 0;
  spq_pkg::res_t pending_results[$];
  dir_row_t dir_rows[$];

  int fail_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;
  int rx_hold_left = 0;

  int gen_count = 0;
  bit fill_mode = 1'b1;
  int boundary_hits = 0;

  sorted_priority_queue_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .item_value_i (item_value_i),
    .empty        (empty),
    .pop          (pop),
    .head_value_o (head_value_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic spq_pkg::res_t apply_request(input spq_pkg::op_e op,
                                                  input logic [31:0] raw);
    spq_pkg::res_t r;
    int pos;
    r.head = '0;
    r.status = spq_pkg::STATUS_OK;
    case (op)
      spq_pkg::OP_INSERT: begin
        if (held_count >= Capacity) begin
          r.status = spq_pkg::STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_vals[pos] >= $signed(raw)) pos++;
          for (int i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = raw;
          held_count++;
        end
      end
      spq_pkg::OP_PULL, spq_pkg::OP_PEEK: begin
        if (held_count == 0) begin
          r.status = spq_pkg::STATUS_EMPTY;
        end else begin
          r.head = held_vals[0];
          if (op == spq_pkg::OP_PULL) begin
            for (int i = 1; i < held_count; i++) held_vals[i-1] = held_vals[i];
            held_count--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = held_count[spq_pkg::OccW-1:0];
    return r;
  endfunction

  // request and result monitor
  always @(posedge clk_i) begin
    spq_pkg::res_t got;
    spq_pkg::res_t exp_res;
    spq_pkg::res_t pred;
    if (rst_ni) begin
      if (push && !full) begin
        pred = apply_request(spq_pkg::op_e'(kind_i), item_value_i);
        pending_results.push_back(req_typed ? req_want : pred);
      end
      if (pop && !empty) begin
        got.head = head_value_o;
        got.status = status_o;
        got.occupancy = occupancy_o;
        if (pending_results.size() == 0) begin
          $error("result popped with no request pending");
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (got.head !== exp_res.head) begin
            $error("head_value: expected %h, got %h", exp_res.head, got.head);
            fail_count++;
          end
          if (got.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, got.status);
            fail_count++;
          end
          if (got.occupancy !== exp_res.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp_res.occupancy, got.occupancy);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: random pop, with an optional long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        pop <= 1'b0;
        rx_hold_left--;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold_left = RxHoldCycles - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_req(input spq_pkg::op_e op, input logic [31:0] val,
                          input bit typed, input spq_pkg::res_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    kind_i <= op;
    item_value_i <= val;
    req_typed <= typed;
    req_want <= want;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic await_results();
    int guard;
    push <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DrainGuard) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    @(posedge clk_i);
  endtask

  task automatic add_row(input spq_pkg::op_e op, input logic [31:0] val, input bit typed,
                         input logic [31:0] head,
                         input logic [spq_pkg::StatusW-1:0] status, input int occ);
    dir_row_t row;
    row.op = op;
    row.val = val;
    row.typed = typed;
    row.want.head = head;
    row.want.status = status;
    row.want.occupancy = occ[spq_pkg::OccW-1:0];
    dir_rows.push_back(row);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(99);
    if (r < 40) begin
      v = int'($urandom_range(8)) - 4;
    end else if (r < 55) begin
      case ($urandom_range(3))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  // fill/drain sweeps: mostly inserts until full, mostly pulls until empty
  task automatic send_random();
    spq_pkg::op_e op;
    int unsigned r;
    r = $urandom_range(99);
    if (fill_mode) begin
      if (r < 72) op = spq_pkg::OP_INSERT;
      else if (r < 84) op = spq_pkg::OP_PULL;
      else if (r < 96) op = spq_pkg::OP_PEEK;
      else op = spq_pkg::OP_NONE;
    end else begin
      if (r < 20) op = spq_pkg::OP_INSERT;
      else if (r < 70) op = spq_pkg::OP_PULL;
      else if (r < 95) op = spq_pkg::OP_PEEK;
      else op = spq_pkg::OP_NONE;
    end
    case (op)
      spq_pkg::OP_INSERT: begin
        if (gen_count == Capacity) begin
          if (fill_mode) boundary_hits++;
        end else begin
          gen_count++;
        end
      end
      spq_pkg::OP_PULL: begin
        if (gen_count == 0) begin
          if (!fill_mode) boundary_hits++;
        end else begin
          gen_count--;
        end
      end
      spq_pkg::OP_PEEK: if (gen_count == 0 && !fill_mode) boundary_hits++;
      default: ;
    endcase
    if (fill_mode && gen_count == Capacity && boundary_hits >= 3) begin
      fill_mode = 1'b0;
      boundary_hits = 0;
    end else if (!fill_mode && gen_count == 0 && boundary_hits >= 3) begin
      fill_mode = 1'b1;
      boundary_hits = 0;
    end
    send_req(op, (op == spq_pkg::OP_INSERT) ? pick_value() : $urandom(), 1'b0, '0);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n_req);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n_req) send_random();
    await_results();
  endtask

  initial begin
    add_row(spq_pkg::OP_PULL,   32'h1234_5678, 1'b1, '0, spq_pkg::STATUS_EMPTY, 0);
    add_row(spq_pkg::OP_PEEK,   32'hffff_ffff, 1'b1, '0, spq_pkg::STATUS_EMPTY, 0);
    add_row(spq_pkg::OP_NONE,   32'h0000_0000, 1'b1, '0, spq_pkg::STATUS_OK, 0);
    add_row(spq_pkg::OP_INSERT, 32'h8000_0000, 1'b1, '0, spq_pkg::STATUS_OK, 1);
    add_row(spq_pkg::OP_PEEK,   32'h0000_0000, 1'b1, 32'h8000_0000, spq_pkg::STATUS_OK, 1);
    add_row(spq_pkg::OP_INSERT, 32'h7fff_ffff, 1'b1, '0, spq_pkg::STATUS_OK, 2);
    add_row(spq_pkg::OP_PEEK,   32'haaaa_aaaa, 1'b1, 32'h7fff_ffff, spq_pkg::STATUS_OK, 2);
    add_row(spq_pkg::OP_INSERT, 32'h0000_0000, 1'b0, '0, spq_pkg::STATUS_OK, 0);
    add_row(spq_pkg::OP_INSERT, 32'hffff_ffff, 1'b0, '0, spq_pkg::STATUS_OK, 0);
    add_row(spq_pkg::OP_INSERT, 32'h0000_0001, 1'b0, '0, spq_pkg::STATUS_OK, 0);
    add_row(spq_pkg::OP_INSERT, 32'h7fff_ffff, 1'b0, '0, spq_pkg::STATUS_OK, 0);
    add_row(spq_pkg::OP_INSERT, 32'h8000_0000, 1'b0, '0, spq_pkg::STATUS_OK, 0);
    add_row(spq_pkg::OP_NONE,   32'hffff_ffff, 1'b0, '0, spq_pkg::STATUS_OK, 0);
    add_row(spq_pkg::OP_PEEK,   32'h5555_5555, 1'b0, '0, spq_pkg::STATUS_OK, 0);
    repeat (7) add_row(spq_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0, spq_pkg::STATUS_OK, 0);
    add_row(spq_pkg::OP_PULL,   32'hffff_ffff, 1'b1, '0, spq_pkg::STATUS_EMPTY, 0);
    add_row(spq_pkg::OP_PEEK,   32'h0000_0000, 1'b1, '0, spq_pkg::STATUS_EMPTY, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 28;
    rx_idle_pct = 59;
    foreach (dir_rows[i]) send_req(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed,
                                   dir_rows[i].want);
    await_results();

    gen_count = 0;
    fill_mode = 1'b1;
    run_phase(28, 59, 350);
    run_phase(59, 28, 350);
    rx_hold_req = 1'b1;
    run_phase(0, 0, 350);

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[sorted_priority_queue_core] OK");
    end else begin
      $display("[sorted_priority_queue_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[sorted_priority_queue_core] ERROR");
    $finish;
  end

endmodule
